// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ycpu_pkg.sv =====
`default_nettype none
package ycpu_pkg;
  localparam int PosW = 24;
  localparam int AngW = 16;
  localparam int CordSteps = 24;
  localparam int StepW = 5;
  localparam int TrigW = 34;
  localparam logic signed [TrigW-1:0] CordK = 34'sd652032874;
  localparam int QDepth = 2;

  typedef enum logic [2:0] {
    FN_ORBIT = 3'd0,
    FN_LOOK = 3'd1,
    FN_ADVANCE = 3'd2,
    FN_STRAFE = 3'd3,
    FN_RELOAD = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    CFG_DIST = 3'd0,
    CFG_EYE_X = 3'd1,
    CFG_EYE_Z = 3'd2,
    CFG_TGT_X = 3'd3,
    CFG_TGT_Z = 3'd4,
    CFG_YAW = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL_A,
    ST_MUL_B,
    ST_WRITE,
    ST_OUT
  } back_state_t;

  // Classified command between the front and the back.
  typedef struct packed {
    logic [2:0] func;
    logic signed [PosW-1:0] amount;
  } cmd_t;

  function automatic logic signed [31:0] atan_entry(input logic [StepW-1:0] i);
    logic signed [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'sd536870912;   5'd1: r = 32'sd316933406;
        5'd2: r = 32'sd167458907;   5'd3: r = 32'sd85004756;
        5'd4: r = 32'sd42667331;    5'd5: r = 32'sd21354465;
        5'd6: r = 32'sd10679838;    5'd7: r = 32'sd5340245;
        5'd8: r = 32'sd2670163;     5'd9: r = 32'sd1335087;
        5'd10: r = 32'sd667544;     5'd11: r = 32'sd333772;
        5'd12: r = 32'sd166886;     5'd13: r = 32'sd83443;
        5'd14: r = 32'sd41722;      5'd15: r = 32'sd20861;
        5'd16: r = 32'sd10430;      5'd17: r = 32'sd5215;
        5'd18: r = 32'sd2608;       5'd19: r = 32'sd1304;
        5'd20: r = 32'sd652;        5'd21: r = 32'sd326;
        5'd22: r = 32'sd163;        5'd23: r = 32'sd81;
        default: r = 32'sd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/yaw_camera_pose_update.sv =====
// Channel | Dir | tdata fields (low bit up)                         | tuser
// s_axis  | in  | amount[23:0]                                      | func[2:0]
// m_axis  | out | eye_x, eye_z, target_x, target_z, yaw_out          | saturated
// cfg     | in  | cfg_we, cfg_index[2:0], cfg_data[23:0]
//
// Each item passes through the execution unit as one pop, one CORDIC seed,
// 24 CORDIC iterations (sin/cos on one shared shift-add unit), two
// multiplier passes, one write-back and a result state that is held until
// m_tready is high.
// A two-entry queue sits between the input side and the execution unit, so
// up to two items are taken while a result waits.
// rst is synchronous, active high; it restores the reset pose and registers.
`default_nettype none
module yaw_camera_pose_update
  import ycpu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [23:0] s_tdata, // amount
  input  wire logic [7:0] s_tuser, // func[2:0], zero padded
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [119:0] m_tdata, // eye_x, eye_z, target_x, target_z, yaw_out
  output logic [7:0] m_tuser, // saturated, zero padded
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [23:0] cfg_data
);
  logic [22:0] orbit_dist;
  logic signed [23:0] st_eye_x, st_eye_z, st_tgt_x, st_tgt_z;
  logic [15:0] st_yaw;
  logic full, q_valid, q_pop;
  cmd_t q_cmd;
  logic [PosW-1:0] ex, ez, tx, tz;
  logic [AngW-1:0] yw;
  logic sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      orbit_dist <= 23'd4096;
      st_eye_x <= '0;
      st_eye_z <= '0;
      st_tgt_x <= '0;
      st_tgt_z <= 24'sd4096;
      st_yaw <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIST: orbit_dist <= cfg_data[22:0];
        CFG_EYE_X: st_eye_x <= cfg_data;
        CFG_EYE_Z: st_eye_z <= cfg_data;
        CFG_TGT_X: st_tgt_x <= cfg_data;
        CFG_TGT_Z: st_tgt_z <= cfg_data;
        CFG_YAW: st_yaw <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !full;

  ycpu_cmd_queue u_queue (
    .clk(clk), .rst(rst), .s_tdata_func(s_tuser), .s_amount(s_tdata),
    .push(s_tvalid), .full(full), .pop_valid(q_valid), .pop_cmd(q_cmd), .pop(q_pop)
  );

  ycpu_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(q_valid), .cmd(q_cmd), .cmd_pop(q_pop),
    .orbit_dist(orbit_dist), .st_eye_x(st_eye_x), .st_eye_z(st_eye_z),
    .st_tgt_x(st_tgt_x),
    .st_tgt_z(st_tgt_z), .st_yaw(st_yaw), .res_valid(m_tvalid), .res_ready(m_tready),
    .eye_x_out(ex), .eye_z_out(ez), .target_x_out(tx), .target_z_out(tz),
    .yaw_out(yw), .saturated(sat)
  );

  assign m_tdata = {8'd0, yw, tz, tx, ez, ex};
  assign m_tuser = {7'd0, sat};
endmodule
`default_nettype wire

// ===== rtl/core/ycpu_cmd_queue.sv =====
`default_nettype none
`include "assert_macros.svh"
module ycpu_cmd_queue
  import ycpu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [7:0] s_tdata_func,
  input  wire logic signed [PosW-1:0] s_amount,
  input  wire logic push,
  output logic full,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  wire logic pop
);
  cmd_t mem [QDepth];
  logic [0:0] wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'(QDepth));
  assign pop_valid = (count != 2'd0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= '{func: s_tdata_func[2:0], amount: s_amount};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && pop_valid) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 2'(push && !full) - 2'(pop && pop_valid);
    end
  end

  `ASSERT_IMPL(a_cnt_range, clk, rst, 1'b1, count <= 2'(QDepth), "queue count overflow")
  `ASSERT_NEXT(a_push_grows, clk, rst, push && !full && !pop,
    count == $past(count) + 2'd1, "push lost")
endmodule
`default_nettype wire

// ===== rtl/core/ycpu_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module ycpu_back
  import ycpu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic cmd_pop,
  input  wire logic [22:0] orbit_dist,
  input  wire logic signed [23:0] st_eye_x,
  input  wire logic signed [23:0] st_eye_z,
  input  wire logic signed [23:0] st_tgt_x,
  input  wire logic signed [23:0] st_tgt_z,
  input  wire logic [15:0] st_yaw,
  output logic res_valid,
  input  wire logic res_ready,
  output logic [PosW-1:0] eye_x_out,
  output logic [PosW-1:0] eye_z_out,
  output logic [PosW-1:0] target_x_out,
  output logic [PosW-1:0] target_z_out,
  output logic [AngW-1:0] yaw_out,
  output logic saturated
);
  localparam logic signed [PosW+1:0] PosHi = (26'sd1 <<< (PosW-1)) - 26'sd1;
  localparam logic signed [PosW+1:0] PosLo = -(26'sd1 <<< (PosW-1));

  back_state_t state, state_next;
  logic signed [PosW-1:0] eye_x, eye_z, tgt_x, tgt_z;
  logic [AngW-1:0] heading;
  logic [2:0] func;
  logic signed [PosW-1:0] amt;
  logic signed [TrigW-1:0] cx, cy;
  logic signed [32:0] cz;
  logic flip;
  logic [StepW-1:0] step;
  logic [StepW-1:0] it_idx;
  logic signed [PosW-1:0] mul_a;
  logic signed [TrigW-1:0] mul_b;
  logic signed [PosW+TrigW-1:0] prod;
  logic signed [PosW+1:0] term_s, term_c;
  logic sat;
  logic signed [PosW-1:0] out_eye_x, out_eye_z, out_tgt_x, out_tgt_z;
  logic [AngW-1:0] out_yaw;

  function automatic logic signed [PosW+1:0] round_prod(input logic signed [PosW+TrigW-1:0] p);
    logic signed [PosW+TrigW-1:0] r;
    begin
      r = (p + (58'sd1 <<< 29)) >>> 30;
      return r[PosW+1:0];
    end
  endfunction

  function automatic logic signed [PosW+1:0] clip(input logic signed [PosW+1:0] v);
    begin
      if (v > PosHi) return PosHi;
      if (v < PosLo) return PosLo;
      return v;
    end
  endfunction

  function automatic logic over(input logic signed [PosW+1:0] v);
    return (v > PosHi) || (v < PosLo);
  endfunction

  // Angle to 32-bit binary angle with quadrant fold.
  logic [31:0] ang32, ang_f;
  logic q_flip;
  logic [AngW-1:0] new_heading;
  always_comb begin
    unique case (func)
      FN_ORBIT: new_heading = heading - amt[AngW-1:0];
      FN_LOOK: new_heading = heading + amt[AngW-1:0];
      default: new_heading = heading;
    endcase
    ang32 = {new_heading, 16'd0};
    q_flip = (ang32[31:30] == 2'd1) || (ang32[31:30] == 2'd2);
    ang_f = q_flip ? ang32 + 32'h8000_0000 : ang32;
  end

  assign prod = mul_a * mul_b;
  // Step 0 seeds the rotator; steps 1..CordSteps run iterations 0..CordSteps-1.
  assign it_idx = step - 5'd1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd_valid) state_next = ST_CORDIC;
      ST_CORDIC: if (step == 5'(CordSteps)) state_next = ST_MUL_A;
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_WRITE;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT: if (res_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = (state == ST_IDLE) && cmd_valid;
    res_valid = (state == ST_OUT);
    eye_x_out = out_eye_x;
    eye_z_out = out_eye_z;
    target_x_out = out_tgt_x;
    target_z_out = out_tgt_z;
    yaw_out = out_yaw;
    saturated = sat;
  end

  // Multiplier operand selection: first pass gives the sine term, second the cosine.
  logic signed [TrigW-1:0] fx, fy;
  always_comb begin
    fx = flip ? -cx : cx;
    fy = flip ? -cy : cy;
    mul_a = (func == FN_ORBIT || func == FN_LOOK) ? $signed({1'b0, orbit_dist}) : amt;
    mul_b = (state == ST_MUL_A) ? fy : fx;
  end

  logic signed [PosW+1:0] ex, ez, tx, tz, dxs, dzs;
  always_comb begin
    dxs = '0;
    dzs = '0;
    ex = 26'(eye_x);
    ez = 26'(eye_z);
    tx = 26'(tgt_x);
    tz = 26'(tgt_z);
    unique case (func)
      FN_ORBIT: begin
        ex = 26'(tgt_x) + term_s;
        ez = 26'(tgt_z) - term_c;
      end
      FN_LOOK: begin
        tx = 26'(eye_x) - term_s;
        tz = 26'(eye_z) + term_c;
      end
      FN_ADVANCE, FN_STRAFE: begin
        dxs = (func == FN_ADVANCE) ? -term_s : -term_c;
        dzs = (func == FN_ADVANCE) ? term_c : -term_s;
        ex = 26'(eye_x) + dxs;
        ez = 26'(eye_z) + dzs;
        tx = 26'(tgt_x) + dxs;
        tz = 26'(tgt_z) + dzs;
      end
      FN_RELOAD: begin
        ex = 26'(st_eye_x);
        ez = 26'(st_eye_z);
        tx = 26'(st_tgt_x);
        tz = 26'(st_tgt_z);
      end
      default: ;
    endcase
  end

  logic signed [PosW+1:0] c_ex, c_ez, c_tx, c_tz;
  logic [PosW-1:0] w_ex, w_ez, w_tx, w_tz;
  assign c_ex = clip(ex);
  assign c_ez = clip(ez);
  assign c_tx = clip(tx);
  assign c_tz = clip(tz);
  assign w_ex = c_ex[PosW-1:0];
  assign w_ez = c_ez[PosW-1:0];
  assign w_tx = c_tx[PosW-1:0];
  assign w_tz = c_tz[PosW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      eye_x <= '0;
      eye_z <= '0;
      tgt_x <= '0;
      tgt_z <= 24'sd4096;
      heading <= '0;
    end else begin
      state <= state_next;
      if (state == ST_WRITE) begin
        eye_x <= w_ex;
        eye_z <= w_ez;
        tgt_x <= w_tx;
        tgt_z <= w_tz;
        heading <= (func == FN_RELOAD) ? st_yaw : new_heading;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        func <= cmd.func;
        amt <= cmd.amount;
        step <= '0;
      end
      ST_CORDIC: begin
        if (step == 5'd0) begin
          // Seed from the folded angle of the held command.
          flip <= q_flip;
          cz <= 33'($signed(ang_f));
          cx <= CordK;
          cy <= '0;
        end else if (cz >= 0) begin
          cx <= cx - (cy >>> it_idx);
          cy <= cy + (cx >>> it_idx);
          cz <= cz - 33'(atan_entry(it_idx));
        end else begin
          cx <= cx + (cy >>> it_idx);
          cy <= cy - (cx >>> it_idx);
          cz <= cz + 33'(atan_entry(it_idx));
        end
        step <= step + 5'd1;
      end
      ST_MUL_A: term_s <= round_prod(prod);
      ST_MUL_B: term_c <= round_prod(prod);
      ST_WRITE: begin
        sat <= (func == FN_ORBIT) ? (over(ex) || over(ez)) :
               (func == FN_LOOK) ? (over(tx) || over(tz)) :
               (func == FN_ADVANCE || func == FN_STRAFE || func == FN_RELOAD) ?
               (over(ex) || over(ez) || over(tx) || over(tz)) : 1'b0;
        out_eye_x <= w_ex;
        out_eye_z <= w_ez;
        out_tgt_x <= w_tx;
        out_tgt_z <= w_tz;
        out_yaw <= (func == FN_RELOAD) ? st_yaw : new_heading;
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_pop_idle, clk, rst, cmd_pop, state == ST_IDLE, "pop outside idle")
  `ASSERT_NEXT(a_out_hold, clk, rst, res_valid && !res_ready, res_valid, "result dropped")
endmodule
`default_nettype wire

// ===== bench/tb_yaw_camera_pose_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_yaw_camera_pose_update;
  import ycpu_pkg::*;

  // Pose as reported on the output stream.
  typedef struct packed {
    logic [23:0] eye_x;
    logic [23:0] eye_z;
    logic [23:0] tgt_x;
    logic [23:0] tgt_z;
    logic [15:0] yaw;
    logic        sat;
  } pose_t;

  // One directed row: command plus an optional hand-typed expectation.
  typedef struct {
    logic [2:0]  func;
    logic [23:0] amount;
    bit          typed;
    pose_t       want;
  } row_t;

  localparam longint LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;   // amount[23:0]
  logic [7:0]  s_tuser = '0;   // func[2:0], zero padded
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [119:0] m_tdata;       // eye_x, eye_z, target_x, target_z, yaw_out
  logic [7:0]   m_tuser;       // saturated, zero padded
  logic cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  yaw_camera_pose_update u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state and register copy.
  logic signed [23:0] p_ex, p_ez, p_tx, p_tz;
  logic [15:0] p_yaw;
  logic [22:0] r_dist;
  logic [23:0] r_ex, r_ez, r_tx, r_tz;
  logic [15:0] r_yaw;

  pose_t pending_poses[$];
  int errors = 0;
  int src_idle = 0;   // percent of cycles sender idles
  int snk_idle = 0;   // percent of cycles receiver stalls
  bit hold_off = 0;   // long receiver stall request
  longint cycles = 0;

  localparam longint ATAN[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  // 24-step CORDIC, Q1.30 outputs; quadrants 2 and 3 folded by a half turn.
  task automatic trig(input logic [15:0] ang, output longint s, output longint c);
    logic [31:0] a;
    bit flip;
    longint x, y, z, dx, dy;
    a = {ang, 16'h0};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + 32'h8000_0000;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN[i];
      end else begin
        x += dx; y -= dy; z += ATAN[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic longint scale(longint v, longint t);
    return (v * t + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic logic [23:0] clip(longint v, ref bit sat);
    if (v > 8388607) begin
      sat = 1; return 24'h7FFFFF;
    end
    if (v < -8388608) begin
      sat = 1; return 24'h800000;
    end
    return v[23:0];
  endfunction

  // Advance the camera by one command; return the pose it reports.
  task automatic apply_command(input logic [2:0] fn, input logic [23:0] amt,
                               output pose_t r);
    longint s, c, d, a, dx, dz;
    bit sat;
    sat = 0;
    d = longint'(r_dist);
    a = longint'($signed(amt));
    case (fn)
      FN_ORBIT: begin
        p_yaw = p_yaw - amt[15:0];
        trig(p_yaw, s, c);
        p_ex = clip(longint'(p_tx) + scale(d, s), sat);
        p_ez = clip(longint'(p_tz) - scale(d, c), sat);
      end
      FN_LOOK: begin
        p_yaw = p_yaw + amt[15:0];
        trig(p_yaw, s, c);
        p_tx = clip(longint'(p_ex) - scale(d, s), sat);
        p_tz = clip(longint'(p_ez) + scale(d, c), sat);
      end
      FN_ADVANCE, FN_STRAFE: begin
        trig(p_yaw, s, c);
        if (fn == FN_ADVANCE) begin
          dx = -scale(a, s); dz = scale(a, c);
        end else begin
          dx = -scale(a, c); dz = -scale(a, s);
        end
        p_ex = clip(longint'(p_ex) + dx, sat);
        p_ez = clip(longint'(p_ez) + dz, sat);
        p_tx = clip(longint'(p_tx) + dx, sat);
        p_tz = clip(longint'(p_tz) + dz, sat);
      end
      FN_RELOAD: begin
        // start regs are already 24 bit, so no clipping can occur here
        p_ex = r_ex; p_ez = r_ez; p_tx = r_tx; p_tz = r_tz;
        p_yaw = r_yaw;
      end
      default: ;  // unused codes leave the pose alone
    endcase
    r = '{p_ex, p_ez, p_tx, p_tz, p_yaw, sat};
  endtask

  // Register write; block must be idle. The task idles with cfg_we low after each write.
  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DIST:  r_dist = v[22:0];
      CFG_EYE_X: r_ex = v;
      CFG_EYE_Z: r_ez = v;
      CFG_TGT_X: r_tx = v;
      CFG_TGT_Z: r_tz = v;
      CFG_YAW:   r_yaw = v[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one command and wait for acceptance; queue its expected pose.
  task automatic send_command(input logic [2:0] fn, input logic [23:0] amt,
                              input bit typed, input pose_t want);
    pose_t r;
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= amt;
    s_tuser <= {5'b0, fn};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_command(fn, amt, r);
    if (typed && r != want)
      $display("%0t table row disagrees: typed %h predicted %h", $time, want, r);
    pending_poses.push_back(typed ? want : r);
  endtask

  task automatic end_burst();
    s_tvalid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);  // let the back end drain
  endtask

  task automatic random_burst(input int n);
    logic [2:0] fn;
    logic [23:0] amt;
    for (int i = 0; i < n; i++) begin
      fn = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7))
                                     : 3'($urandom_range(FN_RELOAD));
      case ($urandom_range(5))
        0: amt = 24'h7FFFFF;
        1: amt = 24'h800000;
        2: amt = 24'($urandom_range(8192)) - 24'd4096;
        default: amt = 24'($urandom);
      endcase
      send_command(fn, amt, 0, '0);
    end
    end_burst();
  endtask

  // Output side: random stalls plus one long hold-off.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    pose_t got, exp_pose;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[23:0], m_tdata[47:24], m_tdata[71:48], m_tdata[95:72],
              m_tdata[111:96], m_tuser[0]};
      if (pending_poses.size() == 0) begin
        errors++;
        $display("%0t unexpected pose: expected none actual %h", $time, got);
      end else begin
        exp_pose = pending_poses.pop_front();
        if (got != exp_pose) begin
          errors++;
          $display("%0t pose mismatch: expected %h actual %h", $time, exp_pose, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  row_t rows[$];

  initial begin
    r_dist = 23'd4096; r_ex = 0; r_ez = 0; r_tx = 0; r_tz = 24'd4096; r_yaw = 0;
    p_ex = 0; p_ez = 0; p_tx = 0; p_tz = 24'sd4096; p_yaw = 0;

    // Directed: after reset, every op, amount extremes, unused codes, clipping.
    rows.push_back('{3'd5, 24'h0, 1, '{24'd0, 24'd0, 24'd0, 24'd4096, 16'd0, 1'b0}});
    rows.push_back('{3'd7, 24'hFFFFFF, 1,
                     '{24'd0, 24'd0, 24'd0, 24'd4096, 16'd0, 1'b0}});
    rows.push_back('{FN_ORBIT, 24'h000000, 0, '0});
    rows.push_back('{FN_ORBIT, 24'h004000, 0, '0});
    rows.push_back('{FN_LOOK, 24'h008000, 0, '0});
    rows.push_back('{FN_LOOK, 24'hFFFFFF, 0, '0});
    rows.push_back('{FN_ADVANCE, 24'h7FFFFF, 0, '0});
    rows.push_back('{FN_ADVANCE, 24'h7FFFFF, 0, '0});
    rows.push_back('{FN_STRAFE, 24'h800000, 0, '0});
    rows.push_back('{FN_STRAFE, 24'h800000, 0, '0});
    rows.push_back('{FN_ADVANCE, 24'h800000, 0, '0});
    rows.push_back('{FN_ORBIT, 24'h7FFFFF, 0, '0});
    rows.push_back('{FN_LOOK, 24'h800000, 0, '0});
    rows.push_back('{3'd6, 24'h123456, 0, '0});
    rows.push_back('{FN_RELOAD, 24'h0, 1, '{24'd0, 24'd0, 24'd0, 24'd4096, 16'd0, 1'b0}});
    rows.push_back('{FN_STRAFE, 24'h001000, 0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle = 6; snk_idle = 69;
    foreach (rows[i]) send_command(rows[i].func, rows[i].amount, rows[i].typed,
                                   rows[i].want);
    end_burst();

    // Extreme registers, then a reload that must hand them back.
    write_reg(CFG_DIST, 24'h7FFFFF);
    write_reg(CFG_EYE_X, 24'h7FFFFF);
    write_reg(CFG_EYE_Z, 24'h800000);
    write_reg(CFG_TGT_X, 24'h800000);
    write_reg(CFG_TGT_Z, 24'h7FFFFF);
    write_reg(CFG_YAW, 24'h00FFFF);
    send_command(FN_RELOAD, 24'h0, 1,
                 '{24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 16'hFFFF, 1'b0});
    random_burst(200);

    // Long receiver hold-off while the sender keeps offering.
    src_idle = 69; snk_idle = 6;
    write_reg(CFG_DIST, 24'd0);
    write_reg(CFG_YAW, 24'h4000);
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_burst(210);
    join

    src_idle = 0; snk_idle = 0;
    write_reg(CFG_DIST, 24'($urandom_range(40000)));
    write_reg(CFG_EYE_X, 24'($urandom));
    write_reg(CFG_EYE_Z, 24'($urandom));
    write_reg(CFG_TGT_X, 24'($urandom));
    write_reg(CFG_TGT_Z, 24'($urandom));
    write_reg(CFG_YAW, 24'($urandom));
    random_burst(210);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
